// ===== rtl/dsb_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the delay-and-sum beamformer
// depends on nothing; dsb_steer_cfg, dsb_mean, the top level and the testbench import it
package dsb_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int DELAY_W   = 7;
  localparam int SPAN_W    = 7;
  localparam int INDEX_W   = 9;
  localparam int MAX_MICS  = 8;
  localparam int CFG_IDX_W = 3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mic_sample_0;
    logic signed [SAMPLE_W-1:0] mic_sample_1;
    logic signed [SAMPLE_W-1:0] mic_sample_2;
    logic signed [SAMPLE_W-1:0] mic_sample_3;
    logic signed [SAMPLE_W-1:0] mic_sample_4;
    logic signed [SAMPLE_W-1:0] mic_sample_5;
    logic signed [SAMPLE_W-1:0] mic_sample_6;
    logic signed [SAMPLE_W-1:0] mic_sample_7;
    logic                       block_start;
  } dsb_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] beam_sample;
    logic [INDEX_W-1:0]         beam_index;
    logic                       block_last;
  } dsb_out_t;

endpackage

// ===== rtl/dsb_stream_if.sv =====
`timescale 1ns / 1ps
// valid/ready stream channel with a typed payload
// payload types come from dsb_pkg
interface dsb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/dsb_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port, one registered read port
// standalone, no package needed
module dsb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dsb_steer_cfg.sv =====
`timescale 1ns / 1ps
// steering delay registers and the values derived from them at write time
// depends on dsb_pkg
module dsb_steer_cfg #(
  parameter int MIC_COUNT     = 8,
  parameter int HISTORY_DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dsb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsb_pkg::DELAY_W-1:0]      cfg_data,
  output logic [dsb_pkg::SPAN_W-1:0]       span,
  output logic [$clog2(HISTORY_DEPTH)-1:0] lag_mod [MIC_COUNT]
);
  import dsb_pkg::*;

  localparam int SLOT_W = $clog2(HISTORY_DEPTH);

  logic signed [DELAY_W-1:0] delay      [MIC_COUNT];
  logic signed [DELAY_W-1:0] delay_next [MIC_COUNT];
  logic signed [DELAY_W-1:0] hi;
  logic signed [DELAY_W-1:0] lo;
  logic [SPAN_W-1:0]         span_next;
  logic [SLOT_W-1:0]         lag_mod_next [MIC_COUNT];

  // remainder of a lag by the ring depth, by binary long division
  function automatic logic [SLOT_W-1:0] lag_wrap(input logic [SPAN_W-1:0] lag);
    logic [SPAN_W-1:0] r;
    r = lag;
    for (int j = SPAN_W - 1; j >= 0; j--) begin
      if ((HISTORY_DEPTH << j) < (1 << SPAN_W)) begin
        if (r >= SPAN_W'(HISTORY_DEPTH << j)) begin
          r = r - SPAN_W'(HISTORY_DEPTH << j);
        end
      end
    end
    return SLOT_W'(r);
  endfunction

  always_comb begin
    for (int m = 0; m < MIC_COUNT; m++) begin
      delay_next[m] = (cfg_we && cfg_index == CFG_IDX_W'(m)) ? $signed(cfg_data) : delay[m];
    end
    hi = delay_next[0];
    lo = delay_next[0];
    for (int m = 1; m < MIC_COUNT; m++) begin
      if (delay_next[m] > hi) begin
        hi = delay_next[m];
      end
      if (delay_next[m] < lo) begin
        lo = delay_next[m];
      end
    end
    span_next = SPAN_W'((DELAY_W + 1)'(hi) - (DELAY_W + 1)'(lo));
    // lag of mic m behind the newest sample is hi - delay_m
    for (int m = 0; m < MIC_COUNT; m++) begin
      lag_mod_next[m] = lag_wrap(SPAN_W'((DELAY_W + 1)'(hi) - (DELAY_W + 1)'(delay_next[m])));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span <= '0;
      for (int m = 0; m < MIC_COUNT; m++) begin
        delay[m]   <= '0;
        lag_mod[m] <= '0;
      end
    end else if (cfg_we) begin
      span <= span_next;
      for (int m = 0; m < MIC_COUNT; m++) begin
        delay[m]   <= delay_next[m];
        lag_mod[m] <= lag_mod_next[m];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    lag_mod[0] <= SLOT_W'(HISTORY_DEPTH - 1) && span <= SPAN_W'(127))
    else $error("steer cfg: derived lag out of range");

  assert property (@(posedge clk) disable iff (rst)
    !cfg_we |=> $stable(span))
    else $error("steer cfg: span changed without a write");

  assert property (@(posedge clk) disable iff (rst)
    span == '0 |-> lag_mod[MIC_COUNT-1] == '0)
    else $error("steer cfg: zero span with nonzero lag");

endmodule

// ===== rtl/dsb_mean.sv =====
`timescale 1ns / 1ps
// sum of the aligned mic samples and division by the mic count
// two register stages, division by reciprocal multiply; depends on dsb_pkg
module dsb_mean #(
  parameter int MIC_COUNT = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [dsb_pkg::SAMPLE_W-1:0]    samples [MIC_COUNT],
  input  logic [dsb_pkg::INDEX_W-1:0]            index,
  input  logic                                   last,
  dsb_stream_if.source                           beam_out
);
  import dsb_pkg::*;

  localparam int SUM_W   = SAMPLE_W + $clog2(MIC_COUNT);
  localparam int SH      = SUM_W + $clog2(MIC_COUNT);
  localparam int RECIP_W = SH + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  // rounded-up reciprocal: exact floor for every magnitude below 2**SUM_W
  localparam longint unsigned RECIP = ((longint'(1) << SH) + MIC_COUNT - 1) / MIC_COUNT;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic signed [SUM_W-1:0]    sum_next;
  logic signed [SUM_W-1:0]    sum;
  logic                       sum_valid;
  logic [INDEX_W-1:0]         sum_index;
  logic                       sum_last;
  logic [SUM_W-1:0]           mag;
  logic [PROD_W-1:0]          prod;
  logic [SAMPLE_W-1:0]        quot;
  logic signed [SAMPLE_W-1:0] mean;
  dsb_out_t                   result;
  logic                       result_valid;
  logic                       adv_out;
  logic                       adv_sum;

  assign adv_out  = !result_valid || beam_out.ready;
  assign adv_sum  = !sum_valid || adv_out;
  assign in_ready = adv_sum;

  always_comb begin
    sum_next = '0;
    for (int m = 0; m < MIC_COUNT; m++) begin
      sum_next = sum_next + SUM_W'(samples[m]);
    end
  end

  // truncation toward zero: divide the magnitude, restore the sign
  always_comb begin
    mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    prod = PROD_W'(mag) * PROD_W'(RECIP_C);
    quot = prod[SH +: SAMPLE_W];
    mean = sum[SUM_W-1] ? $signed(-quot) : $signed(quot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (adv_sum) begin
        sum_valid <= in_valid;
      end
      if (adv_out) begin
        result_valid <= sum_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_sum) begin
      sum       <= sum_next;
      sum_index <= index;
      sum_last  <= last;
    end
    if (adv_out) begin
      result.beam_sample <= mean;
      result.beam_index  <= sum_index;
      result.block_last  <= sum_last;
    end
  end

  assign beam_out.valid   = result_valid;
  assign beam_out.payload = result;

  assert property (@(posedge clk) disable iff (rst)
    sum_valid && !adv_out |=> sum_valid && $stable(sum))
    else $error("mean: stalled sum lost");

  assert property (@(posedge clk) disable iff (rst)
    adv_out && sum_valid |=> result_valid && result.beam_index == $past(sum_index))
    else $error("mean: index not carried to the result");

  assert property (@(posedge clk) disable iff (rst)
    adv_out && sum_valid && sum == '0 |=> result.beam_sample == '0)
    else $error("mean: zero sum gave a nonzero mean");

endmodule

// ===== rtl/delay_and_sum_beamformer.sv =====
`timescale 1ns / 1ps
// an input passes the stage, sum and result registers; throughput: one transaction per
// cycle unless the output stalls, set by the one write and one read port of each mic
// history ram; a stalled output fills the pipeline bubbles before input backs up; reset
// clears the block position, the steering delays and all valid flags; the history rams
// are not cleared, since each slot is written in a block before it is read
module delay_and_sum_beamformer #(
  parameter int MIC_COUNT     = 8,
  parameter int BLOCK_LEN     = 512,
  parameter int HISTORY_DEPTH = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dsb_pkg::DELAY_W-1:0]   cfg_data,
  dsb_stream_if.sink                    mic_in,
  dsb_stream_if.source                  beam_out
);
  import dsb_pkg::*;

  localparam int POS_W  = $clog2(BLOCK_LEN);
  localparam int SLOT_W = $clog2(HISTORY_DEPTH);

  logic [SPAN_W-1:0]          span;
  logic [SLOT_W-1:0]          lag_mod [MIC_COUNT];
  logic signed [SAMPLE_W-1:0] mic_sample [MAX_MICS];
  logic [POS_W-1:0]           block_position;
  logic [SLOT_W-1:0]          block_slot;
  logic [POS_W-1:0]           pos_cur;
  logic [SLOT_W-1:0]          slot_cur;
  logic [POS_W-1:0]           pos_diff;
  logic                       pos_wrap;
  logic                       accept;
  logic                       has_result;
  logic [SLOT_W-1:0]          rd_slot [MIC_COUNT];
  logic [SAMPLE_W-1:0]        rd_data [MIC_COUNT];
  logic                       stage_valid;
  logic [INDEX_W-1:0]         stage_index;
  logic                       stage_last;
  logic signed [SAMPLE_W-1:0] stage_sample [MIC_COUNT];
  logic                       stage_hit [MIC_COUNT];
  logic signed [SAMPLE_W-1:0] aligned [MIC_COUNT];
  logic                       mean_ready;
  logic                       adv_stage;

  dsb_steer_cfg #(
    .MIC_COUNT     (MIC_COUNT),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .span      (span),
    .lag_mod   (lag_mod)
  );

  assign mic_sample[0] = mic_in.payload.mic_sample_0;
  assign mic_sample[1] = mic_in.payload.mic_sample_1;
  assign mic_sample[2] = mic_in.payload.mic_sample_2;
  assign mic_sample[3] = mic_in.payload.mic_sample_3;
  assign mic_sample[4] = mic_in.payload.mic_sample_4;
  assign mic_sample[5] = mic_in.payload.mic_sample_5;
  assign mic_sample[6] = mic_in.payload.mic_sample_6;
  assign mic_sample[7] = mic_in.payload.mic_sample_7;

  assign adv_stage    = !stage_valid || mean_ready;
  assign mic_in.ready = adv_stage;
  assign accept       = mic_in.valid && adv_stage;

  always_comb begin
    pos_cur    = mic_in.payload.block_start ? '0 : block_position;
    slot_cur   = mic_in.payload.block_start ? '0 : block_slot;
    pos_wrap   = (pos_cur == POS_W'(BLOCK_LEN - 1));
    has_result = (int'(span) < BLOCK_LEN) && (POS_W'(span) <= pos_cur);
    pos_diff   = pos_cur - POS_W'(span);
    // ring slot of each mic, lag already reduced modulo the depth
    for (int m = 0; m < MIC_COUNT; m++) begin
      if (slot_cur >= lag_mod[m]) begin
        rd_slot[m] = slot_cur - lag_mod[m];
      end else begin
        rd_slot[m] = SLOT_W'((SLOT_W + 1)'(slot_cur) + (SLOT_W + 1)'(HISTORY_DEPTH)
                             - (SLOT_W + 1)'(lag_mod[m]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_position <= '0;
      block_slot     <= '0;
      stage_valid    <= 1'b0;
    end else begin
      if (accept) begin
        block_position <= pos_wrap ? '0 : pos_cur + POS_W'(1);
        if (pos_wrap || slot_cur == SLOT_W'(HISTORY_DEPTH - 1)) begin
          block_slot <= '0;
        end else begin
          block_slot <= slot_cur + SLOT_W'(1);
        end
      end
      if (adv_stage) begin
        stage_valid <= accept && has_result;
      end
    end
  end

  // zero lag takes the sample of this same transaction, not the ram read of its slot
  always_ff @(posedge clk) begin
    if (adv_stage) begin
      stage_index <= INDEX_W'(pos_diff);
      stage_last  <= pos_wrap;
      for (int m = 0; m < MIC_COUNT; m++) begin
        stage_sample[m] <= mic_sample[m];
        stage_hit[m]    <= (lag_mod[m] == '0);
      end
    end
  end

  for (genvar g = 0; g < MIC_COUNT; g++) begin : g_hist
    dsb_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (HISTORY_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (accept),
      .waddr (slot_cur),
      .wdata (mic_sample[g]),
      .re    (adv_stage),
      .raddr (rd_slot[g]),
      .rdata (rd_data[g])
    );

    assign aligned[g] = stage_hit[g] ? stage_sample[g] : $signed(rd_data[g]);
  end

  dsb_mean #(
    .MIC_COUNT (MIC_COUNT)
  ) u_mean (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage_valid),
    .in_ready (mean_ready),
    .samples  (aligned),
    .index    (stage_index),
    .last     (stage_last),
    .beam_out (beam_out)
  );

  assert property (@(posedge clk) disable iff (rst)
    int'(block_position) < BLOCK_LEN && int'(block_slot) < HISTORY_DEPTH)
    else $error("beamformer: position counters out of range");

  assert property (@(posedge clk) disable iff (rst)
    block_position == '0 |-> block_slot == '0)
    else $error("beamformer: ring slot out of step with position");

  assert property (@(posedge clk) disable iff (rst)
    accept && mic_in.payload.block_start |=> block_position == POS_W'(1))
    else $error("beamformer: block start did not restart the position");

  assert property (@(posedge clk) disable iff (rst)
    stage_valid && !mean_ready |=> stage_valid && $stable(stage_index))
    else $error("beamformer: stalled stage lost its transaction");

  assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(block_position))
    else $error("beamformer: position moved without a transaction");

endmodule

// ===== dv/tb_delay_and_sum_beamformer.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the delay-and-sum beamformer: directed sample streams at reset
// steering delays and random streams under loaded delays, checked against an in-bench beam predictor
// depends on dsb_pkg, dsb_stream_if and delay_and_sum_beamformer
module tb_delay_and_sum_beamformer;
  import dsb_pkg::*;

  localparam int MICS        = 8;
  localparam int BLOCK_LEN   = 512;
  localparam int HIST_DEPTH  = 128;
  localparam int ITEM_TARGET = 1950;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE      = 10;
  localparam logic [CFG_IDX_W-1:0] STEER_DELAY_0 = 3'd0;

  class beamform_scoreboard;
    logic signed [SAMPLE_W-1:0] ring [MICS][HIST_DEPTH];
    int       delay [MICS];
    int       position;
    dsb_out_t expected_beams [$];
    int       mismatches;

    function new();
      foreach (delay[m]) delay[m] = 0;
      position   = 0;
      mismatches = 0;
    endfunction

    function void set_delay(int mic, int d);
      delay[mic] = d;
    endfunction

    function void note_samples(dsb_in_t t);
      logic signed [SAMPLE_W-1:0] s [MICS];
      int pos, lo, hi, span, idx, sum;
      dsb_out_t r;
      s = '{t.mic_sample_0, t.mic_sample_1, t.mic_sample_2, t.mic_sample_3,
            t.mic_sample_4, t.mic_sample_5, t.mic_sample_6, t.mic_sample_7};
      pos = t.block_start ? 0 : position;
      if (pos >= BLOCK_LEN) pos = 0;
      for (int m = 0; m < MICS; m++) ring[m][pos % HIST_DEPTH] = s[m];
      position = (pos + 1 >= BLOCK_LEN) ? 0 : pos + 1;
      lo = 127;
      hi = -128;
      for (int m = 0; m < MICS; m++) begin
        if (delay[m] < lo) lo = delay[m];
        if (delay[m] > hi) hi = delay[m];
      end
      span = hi - lo;
      if (span >= BLOCK_LEN || pos < span) return;
      idx = pos - span;
      sum = 0;
      for (int m = 0; m < MICS; m++) sum += ring[m][(idx + delay[m] - lo) % HIST_DEPTH];
      // signed division truncates toward zero
      sum = sum / MICS;
      r.beam_sample = sum[SAMPLE_W-1:0];
      r.beam_index  = idx[INDEX_W-1:0];
      r.block_last  = (pos == BLOCK_LEN - 1);
      expected_beams.insert(expected_beams.size(), r);
    endfunction

    function void check_beam(dsb_out_t got);
      dsb_out_t want;
      if (expected_beams.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beam transaction: sample %0d index %0d last %0b",
                   $realtime, got.beam_sample, got.beam_index, got.block_last);
        return;
      end
      want = expected_beams.pop_front();
      if (got.beam_sample !== want.beam_sample || got.beam_index !== want.beam_index ||
          got.block_last !== want.block_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: beam mismatch: expected sample %0d index %0d last %0b, got %0d %0d %0b",
                   $realtime, want.beam_sample, want.beam_index, want.block_last,
                   got.beam_sample, got.beam_index, got.block_last);
      end
    endfunction

    function int pending();
      return expected_beams.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DELAY_W-1:0]   cfg_data;

  dsb_stream_if #(.payload_t(dsb_in_t))  mic_if ();
  dsb_stream_if #(.payload_t(dsb_out_t)) beam_if ();

  beamform_scoreboard tracker = new();

  int send_pct;
  int sink_pct;
  int sink_cycles;
  int sink_hold;
  int quiet_cycles;
  int sent_items;

  delay_and_sum_beamformer #(
    .MIC_COUNT    (MICS),
    .BLOCK_LEN    (BLOCK_LEN),
    .HISTORY_DEPTH(HIST_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .mic_in   (mic_if),
    .beam_out (beam_if)
  );

  always #5 clk = ~clk;

  // no gap unless the pct draw hits, else mostly a short one, rarely a long one
  function automatic int gap_length(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 11))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic dsb_in_t pack_item(logic signed [SAMPLE_W-1:0] s [MICS], bit start);
    dsb_in_t t;
    t.mic_sample_0 = s[0];
    t.mic_sample_1 = s[1];
    t.mic_sample_2 = s[2];
    t.mic_sample_3 = s[3];
    t.mic_sample_4 = s[4];
    t.mic_sample_5 = s[5];
    t.mic_sample_6 = s[6];
    t.mic_sample_7 = s[7];
    t.block_start  = start;
    return t;
  endfunction

  function automatic dsb_in_t random_item(bit start);
    logic signed [SAMPLE_W-1:0] s [MICS];
    foreach (s[m]) s[m] = rand_sample();
    return pack_item(s, start);
  endfunction

  // sink side: stall mode is picked anew whenever its random hold count runs out
  always @(posedge clk) begin
    if (sink_cycles == 0) begin
      sink_pct    = pick_pct();
      sink_cycles = $urandom_range(100, 400);
    end else begin
      sink_cycles--;
    end
    if (sink_hold > 0) begin
      sink_hold--;
      beam_if.ready <= 1'b0;
    end else begin
      beam_if.ready <= 1'b1;
      sink_hold = gap_length(sink_pct);
    end
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (mic_if.valid && mic_if.ready) tracker.note_samples(mic_if.payload);
      if (beam_if.valid && beam_if.ready) tracker.check_beam(beam_if.payload);
      if ((mic_if.valid && mic_if.ready) || (beam_if.valid && beam_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_item(input dsb_in_t item);
    int gap;
    gap = gap_length(send_pct);
    if (gap > 0) begin
      mic_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mic_if.valid   <= 1'b1;
    mic_if.payload <= item;
    @(posedge clk);
    while (!mic_if.ready) @(posedge clk);
    sent_items++;
  endtask

  // wait until every expected beam is out, then let items with no result flush
  task automatic drain();
    mic_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_delays(input int d [MICS]);
    for (int m = 0; m < MICS; m++) begin
      cfg_we    <= 1'b1;
      cfg_index <= STEER_DELAY_0 + m[CFG_IDX_W-1:0];
      cfg_data  <= d[m][DELAY_W-1:0];
      @(posedge clk);
      tracker.set_delay(m, d[m]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_block(input int len, input bit with_start, input bit noisy);
    bit start;
    for (int n = 0; n < len && sent_items < ITEM_TARGET; n++) begin
      start = (n == 0) ? with_start : (noisy && $urandom_range(0, 59) == 0);
      send_item(random_item(start));
    end
  endtask

  task automatic run_directed();
    logic signed [SAMPLE_W-1:0] s [MICS];
    send_pct = 0;
    s = '{default: 16'sh7fff};
    send_item(pack_item(s, 1'b1));
    s = '{default: 16'sh8000};
    send_item(pack_item(s, 1'b0));
    // sum of -4 rounds to zero
    foreach (s[m]) s[m] = (m % 2) ? 16'sh8000 : 16'sh7fff;
    send_item(pack_item(s, 1'b0));
    s = '{default: 16'sh0000};
    s[3] = -16'sd1;
    send_item(pack_item(s, 1'b0));
    s = '{default: 16'sh0000};
    s[0] = -16'sd9;
    send_item(pack_item(s, 1'b0));
    s = '{default: 16'sh0000};
    s[5] = 16'sd15;
    send_item(pack_item(s, 1'b0));
    foreach (s[m]) s[m] = (m % 2) ? 16'sh5555 : 16'shaaaa;
    send_item(pack_item(s, 1'b0));
    foreach (s[m]) s[m] = (m % 2) ? 16'shaaaa : 16'sh5555;
    send_item(pack_item(s, 1'b0));
    // block restart in the middle of a block
    s = '{default: 16'sh7fff};
    send_item(pack_item(s, 1'b1));
    send_pct = 30;
    repeat (8) send_item(random_item(1'b0));
    drain();
  endtask

  task automatic run_random();
    int d [MICS];
    int lo, hi, span, phase, budget, done, len, base;
    bit full;
    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      case (phase)
        0: begin
          foreach (d[m]) d[m] = $signed($urandom_range(0, 127)) - 64;
          d[0] = -64;
          d[7] = 63;
        end
        1: d = '{default: 63};
        2: d = '{default: -64};
        default: begin
          case ($urandom_range(0, 2))
            0: foreach (d[m]) d[m] = $signed($urandom_range(0, 127)) - 64;
            1: begin
              base = $signed($urandom_range(0, 119)) - 64;
              foreach (d[m]) d[m] = base + $signed($urandom_range(0, 8));
            end
            default: d = '{default: $signed($urandom_range(0, 127)) - 64};
          endcase
        end
      endcase
      load_delays(d);
      lo = 127;
      hi = -128;
      foreach (d[m]) begin
        if (d[m] < lo) lo = d[m];
        if (d[m] > hi) hi = d[m];
      end
      span   = hi - lo;
      budget = $urandom_range(100, 350);
      done   = 0;
      while (done < budget && sent_items < ITEM_TARGET) begin
        send_pct = pick_pct();
        full = (done == 0 && phase < 2) || $urandom_range(0, 9) == 0;
        if (full)
          len = BLOCK_LEN + $urandom_range(0, 40);
        else if ($urandom_range(0, 7) == 0)
          len = $urandom_range(1, span + 1);
        else
          len = span + $urandom_range(1, 90);
        // a phase sometimes carries on the block left over from the previous delays
        send_block(len, !(done == 0 && phase > 2 && $urandom_range(0, 2) == 0), !full);
        done += len;
      end
      drain();
      phase++;
    end
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= STEER_DELAY_0;
    cfg_data       <= '0;
    mic_if.valid   <= 1'b0;
    mic_if.payload <= '0;
    send_pct     = 0;
    sink_pct     = 0;
    sink_cycles  = 0;
    sink_hold    = 0;
    quiet_cycles = 0;
    sent_items   = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    repeat (SETTLE) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dsb_pkg.sv
rtl/dsb_stream_if.sv
rtl/dsb_ram.sv
rtl/dsb_steer_cfg.sv
rtl/dsb_mean.sv
rtl/delay_and_sum_beamformer.sv
dv/tb_delay_and_sum_beamformer.sv
